// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, ignored while reset is asserted.
`define GPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define GPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/gpc_pkg.sv -----
package gpc_pkg;

  localparam int REQ_W   = 3;
  localparam int PIN_W   = 7;
  localparam int VAL_W   = 2;
  localparam int MODE_W  = 3;
  localparam int PULL_W  = 2;

  localparam int NUM_PINS_DEF = 103;

  localparam logic [REQ_W-1:0] REQ_SET_DIR   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SET_LEVEL = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SET_PULL  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RD_LEVEL  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RD_MODE   = 3'd4;

  localparam logic [VAL_W-1:0] VAL_PULL_UP   = 2'd1;
  localparam logic [VAL_W-1:0] VAL_PULL_DOWN = 2'd2;

  localparam logic [PULL_W-1:0] PULL_NONE = 2'd0;
  localparam logic [PULL_W-1:0] PULL_UP   = 2'd1;
  localparam logic [PULL_W-1:0] PULL_DOWN = 2'd2;

  localparam logic [MODE_W-1:0] MODE_INPUT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_OUTPUT = 3'd1;

  // One stored entry per pin.
  typedef struct packed {
    logic [PULL_W-1:0] pull;
    logic              level;
    logic [MODE_W-1:0] mode;
  } pin_word_t;

  localparam int WORD_W = $bits(pin_word_t);

  typedef struct packed {
    logic              ok;
    logic              level;
    logic [MODE_W-1:0] mode;
    logic              is_output;
  } pin_res_t;

endpackage

// ----- sv/gpc_ram.sv -----
module gpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/gpc_update.sv -----
module gpc_update (
  input  logic [gpc_pkg::REQ_W-1:0] req_type,
  input  logic [gpc_pkg::VAL_W-1:0] value,
  input  logic                      ok,
  input  gpc_pkg::pin_word_t        old_word,
  output logic                      we,
  output gpc_pkg::pin_word_t        new_word,
  output gpc_pkg::pin_res_t         res
);

  import gpc_pkg::*;

  always_comb begin
    new_word = old_word;
    we       = 1'b0;
    case (req_type)
      REQ_SET_DIR: begin
        // direction replaces the whole mode, alternate functions are lost
        new_word.mode = (value != '0) ? MODE_OUTPUT : MODE_INPUT;
        we            = ok;
      end
      REQ_SET_LEVEL: begin
        new_word.level = (value != '0);
        we             = ok;
      end
      REQ_SET_PULL: begin
        if (value == VAL_PULL_UP) begin
          new_word.pull = PULL_UP;
        end else if (value == VAL_PULL_DOWN) begin
          new_word.pull = PULL_DOWN;
        end else begin
          new_word.pull = PULL_NONE;
        end
        we = ok;
      end
      REQ_RD_LEVEL, REQ_RD_MODE: begin
        we = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (ok) begin
      res.ok        = 1'b1;
      res.level     = new_word.level;
      res.mode      = new_word.mode;
      res.is_output = (new_word.mode == MODE_OUTPUT);
    end else begin
      res = '0;
    end
  end

endmodule

// ----- sv/gpio_pin_control_registers.sv -----
// Channel   Ports                                      Direction
// request   in_valid in_ready in_req_type in_pin in_value   in
// result    out_valid out_ready out_ok out_level out_mode out_is_output   out
//
// One request per cycle sustained while out_ready is high; from acceptance to
// out_valid: pin RAM read, then update/write-back into the result register.
// The single-port-pair pin RAM sets the rate: one read and one write a cycle.
// Reset clears per-pin valid bits at once, no clearing pass; unwritten pins read 0.
// A stalled result holds the update stage; in_ready drops only when both are full.
module gpio_pin_control_registers #(
  parameter int NUM_PINS = gpc_pkg::NUM_PINS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gpc_pkg::REQ_W-1:0]    in_req_type,
  input  logic [gpc_pkg::PIN_W-1:0]    in_pin,
  input  logic [gpc_pkg::VAL_W-1:0]    in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_ok,
  output logic                         out_level,
  output logic [gpc_pkg::MODE_W-1:0]   out_mode,
  output logic                         out_is_output
);

  import gpc_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

  // update stage
  logic             s1_vld_r;
  logic [REQ_W-1:0] s1_req_r;
  logic [VAL_W-1:0] s1_val_r;
  logic [AW-1:0]    s1_addr_r;
  logic             s1_ok_r;

  // last written entry, covers the read issued in the same cycle as its write
  logic             fwd_vld_r;
  logic [AW-1:0]    fwd_addr_r;
  pin_word_t        fwd_word_r;

  logic [NUM_PINS-1:0] entry_vld_r;

  logic     out_vld_r;
  pin_res_t out_res_r;

  logic       in_acc;
  logic       s1_adv;
  logic       in_ok;
  logic [WORD_W-1:0] ram_rdata;
  pin_word_t  old_word;
  pin_word_t  new_word;
  logic       upd_we;
  logic       ram_we;
  pin_res_t   upd_res;

  assign s1_adv = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign in_ok    = (in_pin < PIN_W'(NUM_PINS));
  assign ram_we   = s1_adv && upd_we;

  gpc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_PINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (new_word),
    .re    (in_acc),
    .raddr (in_pin[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == s1_addr_r)) begin
      old_word = fwd_word_r;
    end else if (s1_ok_r && entry_vld_r[s1_addr_r]) begin
      old_word = pin_word_t'(ram_rdata);
    end else begin
      old_word = '0;
    end
  end

  gpc_update u_update (
    .req_type (s1_req_r),
    .value    (s1_val_r),
    .ok       (s1_ok_r),
    .old_word (old_word),
    .we       (upd_we),
    .new_word (new_word),
    .res      (upd_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      fwd_vld_r   <= 1'b0;
      entry_vld_r <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (ram_we) begin
        fwd_vld_r              <= 1'b1;
        entry_vld_r[s1_addr_r] <= 1'b1;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r  <= in_req_type;
      s1_val_r  <= in_value;
      s1_addr_r <= in_pin[AW-1:0];
      s1_ok_r   <= in_ok;
    end
    if (ram_we) begin
      fwd_addr_r <= s1_addr_r;
      fwd_word_r <= new_word;
    end
    if (s1_adv) begin
      out_res_r <= upd_res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_ok        = out_res_r.ok;
  assign out_level     = out_res_r.level;
  assign out_mode      = out_res_r.mode;
  assign out_is_output = out_res_r.is_output;

  `GPC_ASSERT(a_no_write_bad_pin, ram_we |-> s1_ok_r, "write to an invalid pin")
  `GPC_ASSERT(a_bad_pin_zero,
              (out_vld_r && !out_res_r.ok) |-> (out_res_r.mode == MODE_INPUT &&
              !out_res_r.level && !out_res_r.is_output),
              "invalid pin result not zero")
  `GPC_ASSERT(a_mode_range, out_vld_r |-> (out_res_r.mode == MODE_INPUT ||
              out_res_r.mode == MODE_OUTPUT), "stored mode out of range")
  `GPC_ASSERT(a_adv_to_out, s1_adv |=> out_vld_r, "advanced request lost")
  `GPC_ASSERT(a_write_marks, ram_we |=> (fwd_vld_r && entry_vld_r[$past(s1_addr_r)]),
              "written entry not marked valid")
  `GPC_ASSERT_ALWAYS(a_ready_when_empty, !s1_vld_r |-> in_ready, "ready low while empty")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import gpc_pkg::*;

  localparam int RANDOM_ITEMS   = 2000;
  localparam int DIRECTED_ROWS  = 25;
  localparam int HOLD_CYCLES    = 300;
  localparam int PAUSE_AT       = 700;
  localparam int HOLD_AT        = 1200;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;

  // request codes the block does not define
  localparam logic [REQ_W-1:0] REQ_SPARE_5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  localparam logic [PIN_W-1:0] PIN_LAST = PIN_W'(NUM_PINS_DEF - 1);
  localparam logic [PIN_W-1:0] PIN_BAD  = PIN_W'(NUM_PINS_DEF);
  localparam logic [PIN_W-1:0] PIN_TOP  = '1;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [PIN_W-1:0] pin;
    logic [VAL_W-1:0] val;
    logic             typed;
    pin_res_t         res;
  } pin_request_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [REQ_W-1:0]   in_req_type;
  logic [PIN_W-1:0]   in_pin;
  logic [VAL_W-1:0]   in_value;
  logic               out_valid;
  logic               out_ready;
  logic               out_ok;
  logic               out_level;
  logic [MODE_W-1:0]  out_mode;
  logic               out_is_output;

  // expectation typed into the directed table travels with the request
  logic               cur_typed;
  pin_res_t           cur_typed_res;

  // shadow copy of the per-pin stores
  logic [MODE_W-1:0]  pin_mode   [NUM_PINS_DEF];
  logic               pin_level  [NUM_PINS_DEF];
  logic [PULL_W-1:0]  pin_pull   [NUM_PINS_DEF];

  pin_res_t           pending_res_q[$];
  pin_request_t       directed_rows[DIRECTED_ROWS];
  logic [PIN_W-1:0]   hot_pins[4];

  int req_count;
  int res_count;
  int bad_count;
  int bad_pin_count;
  int spare_count;
  int hold_count;
  int tx_calm_left;
  bit hold_off_req;

  gpio_pin_control_registers dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_pin        (in_pin),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ok        (out_ok),
    .out_level     (out_level),
    .out_mode      (out_mode),
    .out_is_output (out_is_output)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic pin_res_t apply_pin_request(input logic [REQ_W-1:0] rq,
                                                 input logic [PIN_W-1:0] p,
                                                 input logic [VAL_W-1:0] v);
    pin_res_t r;
    r = '0;
    if (p >= NUM_PINS_DEF) return r;
    case (rq)
      REQ_SET_DIR: begin
        pin_mode[p] = (v != '0) ? MODE_OUTPUT : MODE_INPUT;
      end
      REQ_SET_LEVEL: begin
        pin_level[p] = (v != '0);
      end
      REQ_SET_PULL: begin
        // undefined pull code falls back to none
        pin_pull[p] = (v == VAL_PULL_UP) ? PULL_UP :
                      (v == VAL_PULL_DOWN) ? PULL_DOWN : PULL_NONE;
      end
      default: begin
      end
    endcase
    r.ok        = 1'b1;
    r.level     = pin_level[p];
    r.mode      = pin_mode[p];
    r.is_output = (pin_mode[p] == MODE_OUTPUT);
    return r;
  endfunction

  function automatic pin_request_t mk_row(input logic [REQ_W-1:0] rq,
                                          input logic [PIN_W-1:0] p,
                                          input logic [VAL_W-1:0] v,
                                          input logic typed,
                                          input logic ok, input logic lvl,
                                          input logic [MODE_W-1:0] md,
                                          input logic is_out);
    pin_request_t row;
    row.req           = rq;
    row.pin           = p;
    row.val           = v;
    row.typed         = typed;
    row.res.ok        = ok;
    row.res.level     = lvl;
    row.res.mode      = md;
    row.res.is_output = is_out;
    return row;
  endfunction

  function automatic int pick_gap();
    int r;
    if (hold_off_req) return 0;
    if (tx_calm_left > 0) begin
      tx_calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      tx_calm_left = $urandom_range(30, 100);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(input pin_request_t row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= row.req;
    in_pin        <= row.pin;
    in_value      <= row.val;
    cur_typed     <= row.typed;
    cur_typed_res <= row.res;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic note_mismatch(input pin_res_t want, input pin_res_t got,
                               input bit orphan);
    bad_count++;
    if (bad_count > MAX_REPORTS) return;
    if (orphan)
      $display("[%0t] mismatch: result with no pending request,",
               " got ok=%b lvl=%b mode=%0d out=%b",
               $realtime, got.ok, got.level, got.mode, got.is_output);
    else
      $display("[%0t] mismatch on result %0d:",
               " exp ok=%b lvl=%b mode=%0d out=%b,",
               " got ok=%b lvl=%b mode=%0d out=%b",
               $realtime, res_count, want.ok, want.level, want.mode, want.is_output,
               got.ok, got.level, got.mode, got.is_output);
  endtask

  // predict on request acceptance, compare on result acceptance
  always @(posedge clk) begin : check_results
    pin_res_t want;
    pin_res_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = apply_pin_request(in_req_type, in_pin, in_value);
        if (cur_typed) want = cur_typed_res;
        pending_res_q.push_back(want);
        req_count++;
        if (in_pin >= NUM_PINS_DEF) bad_pin_count++;
        if (in_req_type > REQ_RD_MODE) spare_count++;
      end
      if (out_valid && out_ready) begin
        got.ok        = out_ok;
        got.level     = out_level;
        got.mode      = out_mode;
        got.is_output = out_is_output;
        if (pending_res_q.size() == 0) begin
          note_mismatch('0, got, 1'b1);
        end else begin
          want = pending_res_q.pop_front();
          res_count++;
          if (got.ok !== want.ok || got.level !== want.level ||
              got.mode !== want.mode || got.is_output !== want.is_output)
            note_mismatch(want, got, 1'b0);
        end
      end
    end
  end

  // result side: random stalls, calm windows, one long hold-off on request
  initial begin : result_sink
    int r;
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    out_ready  = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        hold_count++;
      end else if (calm_left > 0) begin
        out_ready <= 1'b1;
        calm_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) calm_left = $urandom_range(40, 120);
        else if (r < 25) stall_left = $urandom_range(1, 3);
        else if (r < 28) stall_left = $urandom_range(10, 40);
        out_ready <= (stall_left == 0);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL gpio_pin_control_registers");
    $finish;
  end

  initial begin : stimulus
    int n;
    int r;
    pin_request_t row;

    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = '0;
    in_pin        = '0;
    in_value      = '0;
    cur_typed     = 1'b0;
    cur_typed_res = '0;
    hold_off_req  = 1'b0;
    tx_calm_left  = 0;
    req_count     = 0;
    res_count     = 0;
    bad_count     = 0;
    bad_pin_count = 0;
    spare_count   = 0;
    hold_count    = 0;
    for (n = 0; n < NUM_PINS_DEF; n++) begin
      pin_mode[n]  = MODE_INPUT;
      pin_level[n] = 1'b0;
      pin_pull[n]  = PULL_NONE;
    end

    // reads right after reset, pin extremes, invalid pins, spare codes, port edges
    directed_rows[0]  = mk_row(REQ_RD_MODE,   '0,       2'd0, 1, 1, 0, MODE_INPUT,  0);
    directed_rows[1]  = mk_row(REQ_RD_LEVEL,  PIN_LAST, 2'd3, 1, 1, 0, MODE_INPUT,  0);
    directed_rows[2]  = mk_row(REQ_SET_DIR,   '0,       2'd1, 1, 1, 0, MODE_OUTPUT, 1);
    directed_rows[3]  = mk_row(REQ_SET_LEVEL, '0,       2'd1, 1, 1, 1, MODE_OUTPUT, 1);
    directed_rows[4]  = mk_row(REQ_SET_PULL,  '0,       VAL_PULL_DOWN, 0, 0, 0, '0, 0);
    directed_rows[5]  = mk_row(REQ_SET_PULL,  '0,       2'd3, 0, 0, 0, '0, 0);
    directed_rows[6]  = mk_row(REQ_SET_PULL,  '0,       VAL_PULL_UP, 0, 0, 0, '0, 0);
    directed_rows[7]  = mk_row(REQ_SET_DIR,   PIN_LAST, 2'd3, 1, 1, 0, MODE_OUTPUT, 1);
    directed_rows[8]  = mk_row(REQ_SET_DIR,   PIN_LAST, 2'd0, 1, 1, 0, MODE_INPUT,  0);
    directed_rows[9]  = mk_row(REQ_SET_LEVEL, PIN_LAST, 2'd2, 1, 1, 1, MODE_INPUT,  0);
    directed_rows[10] = mk_row(REQ_SET_LEVEL, PIN_LAST, 2'd0, 1, 1, 0, MODE_INPUT,  0);
    directed_rows[11] = mk_row(REQ_SET_DIR,   PIN_BAD,  2'd1, 1, 0, 0, '0, 0);
    directed_rows[12] = mk_row(REQ_SET_LEVEL, PIN_TOP,  2'd3, 1, 0, 0, '0, 0);
    directed_rows[13] = mk_row(REQ_SET_PULL,  PIN_BAD,  2'd2, 1, 0, 0, '0, 0);
    directed_rows[14] = mk_row(REQ_RD_MODE,   PIN_TOP,  2'd0, 1, 0, 0, '0, 0);
    directed_rows[15] = mk_row(REQ_SPARE_5,   '0,       2'd0, 0, 0, 0, '0, 0);
    directed_rows[16] = mk_row(REQ_SPARE_6,   PIN_TOP,  2'd3, 1, 0, 0, '0, 0);
    directed_rows[17] = mk_row(REQ_SPARE_7,   7'd10,    2'd2, 0, 0, 0, '0, 0);
    directed_rows[18] = mk_row(REQ_SET_DIR,   7'd9,     2'd2, 0, 0, 0, '0, 0);
    directed_rows[19] = mk_row(REQ_SET_DIR,   7'd10,    2'd1, 0, 0, 0, '0, 0);
    directed_rows[20] = mk_row(REQ_SET_LEVEL, 7'd26,    2'd1, 0, 0, 0, '0, 0);
    directed_rows[21] = mk_row(REQ_SET_LEVEL, 7'd27,    2'd1, 0, 0, 0, '0, 0);
    directed_rows[22] = mk_row(REQ_SET_DIR,   7'd51,    2'd1, 0, 0, 0, '0, 0);
    directed_rows[23] = mk_row(REQ_SET_DIR,   7'd52,    2'd2, 0, 0, 0, '0, 0);
    directed_rows[24] = mk_row(REQ_RD_MODE,   7'd51,    2'd0, 0, 0, 0, '0, 0);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (n = 0; n < DIRECTED_ROWS; n++) send_request(directed_rows[n]);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // a few hot pins so that writes are read back soon after
      if (n % 100 == 0)
        foreach (hot_pins[i]) hot_pins[i] = PIN_W'($urandom_range(0, NUM_PINS_DEF - 1));
      if (n == PAUSE_AT) begin
        in_valid <= 1'b0;
        wait (pending_res_q.size() == 0);
        @(negedge clk);
      end
      if (n == HOLD_AT) hold_off_req = 1'b1;

      row = '0;
      r = $urandom_range(0, 99);
      if (r < 10) row.pin = PIN_W'($urandom_range(NUM_PINS_DEF, 127));
      else if (r < 55) row.pin = hot_pins[$urandom_range(0, 3)];
      else row.pin = PIN_W'($urandom_range(0, NUM_PINS_DEF - 1));
      r = $urandom_range(0, 99);
      if (r < 8) row.req = REQ_W'($urandom_range(REQ_SPARE_5, REQ_SPARE_7));
      else row.req = REQ_W'($urandom_range(REQ_SET_DIR, REQ_RD_MODE));
      row.val = VAL_W'($urandom_range(0, 3));
      send_request(row);
    end
    in_valid <= 1'b0;

    wait (pending_res_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d requests (%0d on invalid pins, %0d spare codes),",
             " %0d results checked",
             req_count, bad_pin_count, spare_count, res_count);
    $display("run: %0d long result hold-off, one full drain pause, %0d mismatches",
             hold_count, bad_count);
    if (bad_count == 0)
      $display("PASS gpio_pin_control_registers");
    else
      $display("FAIL gpio_pin_control_registers");
    $finish;
  end

endmodule

// ----- gpio_pin_control_registers.f -----
+incdir+sv
sv/gpc_pkg.sv
sv/gpc_ram.sv
sv/gpc_update.sv
sv/gpio_pin_control_registers.sv
bench/tb_top.sv
